// ===== src/lsac_pkg.sv =====
// shared constants for the lidar sector avoid controller
package lsac_pkg;

  localparam int SECTORS = 72;
  localparam int SEC_W   = 7;

  // input word kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_CAMERA = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // drive modes
  localparam logic [1:0] MODE_GO       = 2'd0;
  localparam logic [1:0] MODE_BLOCKED  = 2'd1;
  localparam logic [1:0] MODE_FINISHED = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ANGLE_START = 3'd0;
  localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] CFG_AVOID_DIST  = 3'd2;
  localparam logic [2:0] CFG_MOVE_UNIT   = 3'd3;
  localparam logic [2:0] CFG_OBJECT_SIZE = 3'd4;

  localparam logic signed [25:0] FULL_TURN   = 26'sd92160;
  localparam logic [16:0]        RECIP_FIVE  = 17'd205;
  localparam logic [15:0]        NO_RANGE    = 16'hFFFF;
  localparam logic [15:0]        NO_RETURN_MM = 16'd8000;
  localparam logic [15:0]        TARGET_MIN  = 16'd1000;
  localparam logic [SEC_W-1:0]   MID_FIRST   = 7'd49;
  localparam logic [SEC_W-1:0]   MID_LAST    = 7'd59;
  localparam logic signed [12:0] TURN_SPEED  = 13'sd15;
  localparam logic signed [12:0] CRUISE      = 13'sd50;
  localparam logic signed [4:0]  PARTS_P1    = 5'sd11;

endpackage

// ===== src/lidar_sector_avoid_controller.sv =====
// lidar sector avoid controller: sector minimum table and drive state machine
//
// usage: present a word on the input ports with start high; it is taken at a
// clock edge where start is high and busy is low. kind 0 is a range sample,
// kind 1 a camera report, kind 2 a control tick, kind 3 is ignored.
// range samples go in order: the accept cycle registers angle_step times
// sample_index, the next forms the sector and reads the table memory, the
// last compares and writes back. a tick walks sectors 49 to 59 through the
// single memory read port, one a cycle, and keeps busy high while it runs;
// its result shows with done in the first cycle busy is low again.
// camera reports and kind 3 finish in the accept cycle and never raise busy.
// only ticks give a result: left_drive, right_drive, mode, middle_blocked are
// valid while done is high for one cycle; the receiver cannot stall it.
// the next word may be accepted in the same cycle as done.
// configuration goes through cfg_we / cfg_addr / cfg_data, one register per
// write; the user must write only while the block is idle; the block does not enforce it.
// reset (rst, synchronous) clears the table to no reading through per-sector
// valid bits, restores register defaults and sets mode go.
module lidar_sector_avoid_controller
  import lsac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic               scan_start,
  input  logic [11:0]        sample_index,
  input  logic [15:0]        range_mm,
  input  logic               no_return,
  input  logic [9:0]         object_center,
  input  logic [15:0]        obj_extent,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [17:0]        cfg_data,
  output logic               done,
  output logic signed [12:0] left_drive,
  output logic signed [12:0] right_drive,
  output logic [1:0]         mode,
  output logic               middle_blocked
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_WR    = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration
  logic signed [17:0] angle_start;
  logic [11:0]        angle_step;
  logic [15:0]        avoid_distance_mm;
  logic [7:0]         drive_gain;
  logic [13:0]        object_size;

  // control state
  logic [1:0]         mode_reg;
  logic               ignore_obstacles;
  logic [9:0]         camera_center;
  logic [15:0]        cam_extent;
  logic signed [12:0] left_hold;
  logic signed [12:0] right_hold;
  logic               hit;
  logic               rd_pend;
  logic [SEC_W-1:0]   scan_sec;

  // sample path
  logic [23:0]        prod;
  logic [15:0]        dist_q;
  logic [SEC_W-1:0]   wr_sec;
  logic               wr_ok;

  // table memory and per-sector valid bits
  logic [15:0]        mem [SECTORS];
  logic [SECTORS-1:0] sec_valid;
  logic [15:0]        rd_data;
  logic               rd_valid;
  logic [SEC_W-1:0]   rd_addr;
  logic               mem_we;
  logic [15:0]        cur_min;

  logic               accept;
  logic signed [25:0] angle_sum;
  logic signed [25:0] angle_wrap;
  logic               angle_ok;
  logic [16:0]        sec_prod;
  logic [SEC_W-1:0]   sector;

  // tick arithmetic
  logic [15:0]        size_x3;
  logic               ignore_next;
  logic               finish_now;
  logic [3:0]         part;
  logic [12:0]        left_calc;
  logic signed [13:0] right_calc;
  logic [1:0]         mode_next;
  logic signed [12:0] left_next;
  logic signed [12:0] right_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  assign left_drive  = left_hold;
  assign right_drive = right_hold;
  assign mode        = mode_reg;

  // angle -> sector, angle / 1280 as (angle >> 8) * 205 >> 10
  assign angle_sum  = $signed({{8{angle_start[17]}}, angle_start}) + $signed({2'b00, prod});
  assign angle_wrap = angle_sum[25] ? (angle_sum + FULL_TURN) : angle_sum;
  assign angle_ok   = !angle_wrap[25] && (angle_wrap < FULL_TURN);
  assign sec_prod   = {8'd0, angle_wrap[16:8]} * RECIP_FIVE;
  assign sector     = sec_prod[16:10];

  assign rd_addr = (state == ST_ADDR) ? sector : scan_sec;
  assign cur_min = rd_valid ? rd_data : NO_RANGE;
  assign mem_we  = (state == ST_WR) && wr_ok && (dist_q < cur_min);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_sec] <= dist_q;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= sec_valid[rd_addr];
      if (accept && kind == KIND_SAMPLE && scan_start) begin
        sec_valid <= '0;
      end else if (mem_we) begin
        sec_valid[wr_sec] <= 1'b1;
      end
    end
  end

  // tick decision
  assign size_x3     = {2'b00, object_size} * 16'd3;
  assign ignore_next = ignore_obstacles || (cam_extent > {2'b00, object_size});
  assign finish_now  = (mode_reg == MODE_FINISHED) || (cam_extent > size_x3);
  assign part        = camera_center[9:6];
  assign left_calc   = ({1'b0, part} + 5'd1) * {5'd0, drive_gain};
  assign right_calc  = (PARTS_P1 - $signed({1'b0, part})) * $signed({1'b0, drive_gain});

  always_comb begin
    mode_next  = mode_reg;
    left_next  = left_hold;
    right_next = right_hold;
    if (finish_now) begin
      mode_next  = MODE_FINISHED;
      left_next  = '0;
      right_next = '0;
    end else if (mode_reg == MODE_BLOCKED) begin
      if (hit) begin
        left_next  = -TURN_SPEED;
        right_next = TURN_SPEED;
      end else begin
        mode_next = MODE_GO;
      end
    end else if (!ignore_next && hit) begin
      mode_next = MODE_BLOCKED;
    end else if (cam_extent < TARGET_MIN) begin
      left_next  = CRUISE;
      right_next = CRUISE;
    end else begin
      left_next  = $signed(left_calc);
      right_next = right_calc[12:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_SAMPLE) begin
          state_next = ST_ADDR;
        end else if (accept && kind == KIND_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_ADDR:  state_next = ST_WR;
      ST_WR:    state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_sec == MID_LAST) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_EMIT;
      ST_EMIT:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      angle_start       <= -18'sd46080;
      angle_step        <= 12'd256;
      avoid_distance_mm <= 16'd500;
      drive_gain        <= 8'd5;
      object_size       <= 14'd1000;
      mode_reg          <= MODE_GO;
      ignore_obstacles  <= 1'b0;
      camera_center     <= '0;
      cam_extent        <= '0;
      left_hold         <= '0;
      right_hold        <= '0;
      done              <= 1'b0;
      middle_blocked    <= 1'b0;
      hit               <= 1'b0;
      rd_pend           <= 1'b0;
      scan_sec          <= MID_FIRST;
    end else begin
      state <= state_next;
      done  <= (state == ST_EMIT);

      if (cfg_we) begin
        case (cfg_addr)
          CFG_ANGLE_START: angle_start       <= $signed(cfg_data);
          CFG_ANGLE_STEP:  angle_step        <= cfg_data[11:0];
          CFG_AVOID_DIST:  avoid_distance_mm <= cfg_data[15:0];
          CFG_MOVE_UNIT:   drive_gain        <= cfg_data[7:0];
          CFG_OBJECT_SIZE: object_size       <= cfg_data[13:0];
          default: ;
        endcase
      end

      if (accept && kind == KIND_CAMERA) begin
        camera_center <= object_center;
        cam_extent    <= obj_extent;
      end

      if (accept && kind == KIND_TICK) begin
        scan_sec <= MID_FIRST;
        hit      <= 1'b0;
      end

      rd_pend <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        scan_sec <= scan_sec + 7'd1;
      end
      // read data is registered, so it lags the address
      if ((state == ST_SCAN || state == ST_FLUSH) && rd_pend &&
          (cur_min < avoid_distance_mm)) begin
        hit <= 1'b1;
      end

      if (state == ST_EMIT) begin
        ignore_obstacles <= ignore_next;
        mode_reg         <= mode_next;
        left_hold        <= left_next;
        right_hold       <= right_next;
        middle_blocked   <= hit;
      end
    end
  end

  // sample path registers
  always_ff @(posedge clk) begin
    if (accept) begin
      prod   <= angle_step * sample_index;
      dist_q <= no_return ? NO_RETURN_MM : range_mm;
    end
    if (state == ST_ADDR) begin
      wr_sec <= sector;
      wr_ok  <= angle_ok;
    end
  end

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_EMIT)
    else $error("result strobe without a finished tick");

  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(mode_reg) == MODE_FINISHED && !$past(rst) |-> mode_reg == MODE_FINISHED)
    else $error("finished mode was left");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> wr_sec < SEC_W'(SECTORS))
    else $error("table write beyond last sector");

endmodule

// ===== bench/lsac_checker.sv =====
`timescale 1ns / 100ps
// checker for the lidar sector avoid controller: shadow state, tick prediction, compare
module lsac_checker
  import lsac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic               scan_start,
  input  logic [11:0]        sample_index,
  input  logic [15:0]        range_mm,
  input  logic               no_return,
  input  logic [9:0]         object_center,
  input  logic [15:0]        obj_extent,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [17:0]        cfg_data,
  input  logic               done,
  input  logic signed [12:0] left_drive,
  input  logic signed [12:0] right_drive,
  input  logic [1:0]         mode,
  input  logic               middle_blocked,
  output int                 fails,
  output int                 drives_owed
);

  localparam int SECTOR_SPAN   = 1280;
  localparam int COLUMN_PART   = 64;
  localparam int FINISH_FACTOR = 3;

  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] right;
    logic [1:0]         mode;
    logic               blocked;
  } drive_cmd_t;

  logic signed [17:0] angle_start_r;
  logic [11:0]        angle_step_r;
  logic [15:0]        avoid_r;
  logic [7:0]         drive_gain_r;
  logic [13:0]        object_size_r;

  logic [15:0]        sector_min [SECTORS];
  logic [1:0]         mode_r;
  logic               ignore_r;
  logic [9:0]         cam_center_r;
  logic [15:0]        cam_width_r;
  logic signed [12:0] left_r;
  logic signed [12:0] right_r;

  drive_cmd_t         owed_q [$];
  drive_cmd_t         want;

  task automatic clear_sectors();
    for (int i = 0; i < SECTORS; i++) sector_min[i] = NO_RANGE;
  endtask

  task automatic reset_shadow();
    angle_start_r = -18'sd46080;
    angle_step_r  = 12'd256;
    avoid_r       = 16'd500;
    drive_gain_r  = 8'd5;
    object_size_r = 14'd1000;
    clear_sectors();
    mode_r        = MODE_GO;
    ignore_r      = 1'b0;
    cam_center_r  = '0;
    cam_width_r   = '0;
    left_r        = '0;
    right_r       = '0;
    owed_q.delete();
  endtask

  task automatic fold_sample();
    int ang;
    int sec;
    logic [15:0] sample_mm;
    if (scan_start) clear_sectors();
    ang = int'(angle_start_r) + int'(angle_step_r) * int'(sample_index);
    if (ang < 0) ang += int'(FULL_TURN);
    // still negative after one wrap, or a full turn or beyond: dropped
    if (ang < 0 || ang >= int'(FULL_TURN)) return;
    sec = ang / SECTOR_SPAN;
    sample_mm = no_return ? NO_RETURN_MM : range_mm;
    if (sample_mm < sector_min[sec]) sector_min[sec] = sample_mm;
  endtask

  function automatic logic middle_near();
    logic hit;
    hit = 1'b0;
    for (int i = int'(MID_FIRST); i <= int'(MID_LAST); i++)
      if (sector_min[i] < avoid_r) hit = 1'b1;
    return hit;
  endfunction

  function automatic drive_cmd_t predict_tick();
    drive_cmd_t cmd;
    logic near;
    int part;
    near = middle_near();
    if (int'(cam_width_r) > int'(object_size_r)) ignore_r = 1'b1;
    if (int'(cam_width_r) > FINISH_FACTOR * int'(object_size_r)) mode_r = MODE_FINISHED;
    case (mode_r)
      MODE_FINISHED: begin
        left_r  = '0;
        right_r = '0;
      end
      MODE_BLOCKED: begin
        if (near) begin
          left_r  = -TURN_SPEED;
          right_r = TURN_SPEED;
        end else begin
          mode_r = MODE_GO;
        end
      end
      default: begin
        if (!ignore_r && near) begin
          mode_r = MODE_BLOCKED;
        end else if (cam_width_r < TARGET_MIN) begin
          left_r  = CRUISE;
          right_r = CRUISE;
        end else begin
          part    = int'(cam_center_r) / COLUMN_PART;
          left_r  = 13'((part + 1) * int'(drive_gain_r));
          right_r = 13'((int'(PARTS_P1) - part) * int'(drive_gain_r));
        end
      end
    endcase
    cmd.left    = left_r;
    cmd.right   = right_r;
    cmd.mode    = mode_r;
    cmd.blocked = near;
    return cmd;
  endfunction

  task automatic check_field(string name, logic signed [15:0] exp_v, logic signed [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_shadow();
    end else begin
      // results first: a word taken at this edge cannot have its result here
      if (done === 1'b1) begin
        if (owed_q.size() == 0) begin
          $error("tick result with no tick waiting");
          fails++;
        end else begin
          want = owed_q.pop_front();
          check_field("left_drive", want.left, left_drive);
          check_field("right_drive", want.right, right_drive);
          check_field("mode", want.mode, mode);
          check_field("middle_blocked", want.blocked, middle_blocked);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ANGLE_START: angle_start_r = cfg_data;
          CFG_ANGLE_STEP:  angle_step_r  = cfg_data[11:0];
          CFG_AVOID_DIST:  avoid_r       = cfg_data[15:0];
          CFG_MOVE_UNIT:   drive_gain_r  = cfg_data[7:0];
          CFG_OBJECT_SIZE: object_size_r = cfg_data[13:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (kind)
          KIND_SAMPLE: fold_sample();
          KIND_CAMERA: begin
            cam_center_r = object_center;
            cam_width_r  = obj_extent;
          end
          KIND_TICK: owed_q.push_back(predict_tick());
          default: ;
        endcase
      end
    end
    drives_owed <= owed_q.size();
  end

endmodule

// ===== bench/tb_lidar_sector_avoid_controller.sv =====
`timescale 1ns / 100ps
// testbench top for the lidar sector avoid controller: stimulus, config phases, verdict
module tb_lidar_sector_avoid_controller;
  import lsac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // how far camera widths may go in a phase: sticky flags must not fire too early
  localparam int WIDTH_KEEP   = 0;
  localparam int WIDTH_IGNORE = 1;
  localparam int WIDTH_ANY    = 2;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = KIND_SAMPLE;
  logic               scan_start = 1'b0;
  logic [11:0]        sample_index = '0;
  logic [15:0]        range_mm = '0;
  logic               no_return = 1'b0;
  logic [9:0]         object_center = '0;
  logic [15:0]        obj_extent = '0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = CFG_ANGLE_START;
  logic [17:0]        cfg_data = '0;
  logic               done;
  logic signed [12:0] left_drive;
  logic signed [12:0] right_drive;
  logic [1:0]         mode;
  logic               middle_blocked;
  int                 fails;
  int                 drives_owed;

  int cycles = 0;
  int burst_left = 0;
  int cur_start = -46080;
  int cur_step = 256;
  int cur_avoid = 500;
  int cur_osize = 1000;
  int width_policy = WIDTH_KEEP;

  lidar_sector_avoid_controller i_dut (.*);

  lsac_checker i_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] k, logic ss, logic [11:0] idx, logic [15:0] rng,
                           logic nr, logic [9:0] cen, logic [15:0] wid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start         <= 1'b1;
    kind          <= k;
    scan_start    <= ss;
    sample_index  <= idx;
    range_mm      <= rng;
    no_return     <= nr;
    object_center <= cen;
    obj_extent    <= wid;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every tick result is back and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (drives_owed != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= 18'(val);
    @(posedge clk);
  endtask

  // sample index whose angle lands on ang under the current setting
  function automatic logic [11:0] aim_index(int ang);
    int off;
    if (cur_step == 0) return 12'($urandom_range(0, 4095));
    off = ang - int'(FULL_TURN) - cur_start;
    if (off < 0) off = ang - cur_start;
    if (off < 0 || off / cur_step > 4095) return 12'($urandom_range(0, 4095));
    return 12'(off / cur_step);
  endfunction

  task automatic random_word();
    int pick;
    int ang;
    int ceil_w;
    logic [11:0] idx;
    logic [15:0] rng;
    logic [15:0] wid;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 2))
        0:       ang = $urandom_range(62720, 76799);  // middle sectors
        1:       ang = $urandom_range(0, 92159);
        default: ang = -1;
      endcase
      idx = (ang < 0) ? 12'($urandom_range(0, 4095)) : aim_index(ang);
      if ($urandom_range(0, 4) < 2)
        rng = 16'($urandom_range(0, (2 * cur_avoid > 65534) ? 65534 : 2 * cur_avoid));
      else
        rng = 16'($urandom_range(0, 65534));
      send_word(KIND_SAMPLE, $urandom_range(0, 39) == 0, idx, rng,
                $urandom_range(0, 7) == 0, 10'($urandom), 16'($urandom));
    end else if (pick < 78) begin
      case (width_policy)
        WIDTH_KEEP:   ceil_w = cur_osize;
        WIDTH_IGNORE: ceil_w = (3 * cur_osize > 65535) ? 65535 : 3 * cur_osize;
        default:      ceil_w = 65535;
      endcase
      wid = 16'($urandom_range(0, ceil_w));
      send_word(KIND_CAMERA, 1'($urandom), 12'($urandom), 16'($urandom), 1'($urandom),
                10'($urandom_range(0, 1023)), wid);
    end else begin
      send_word(KIND_TICK, 1'($urandom), 12'($urandom), 16'($urandom), 1'($urandom),
                10'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(int a_start, int a_step, int avoid, int unit, int osize,
                           int policy, int items);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cur_start    = a_start;
    cur_step     = a_step;
    cur_avoid    = avoid;
    cur_osize    = osize;
    width_policy = policy;
    write_reg(CFG_ANGLE_START, a_start);
    write_reg(CFG_ANGLE_STEP, a_step);
    write_reg(CFG_AVOID_DIST, avoid);
    write_reg(CFG_MOVE_UNIT, unit);
    write_reg(CFG_OBJECT_SIZE, osize);
    cfg_we <= 1'b0;
    // forget any wide object left over from the previous setting
    send_word(KIND_CAMERA, 1'b0, '0, '0, 1'b0, 10'($urandom_range(0, 1023)), 16'd0);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 24) == 0)
        send_word(KIND_UNUSED, 1'($urandom), 12'($urandom), 16'($urandom), 1'($urandom),
                  10'($urandom), 16'($urandom));
      if ($urandom_range(0, 79) == 0) wait_drained();
      random_word();
    end
  endtask

  task automatic rand_phase(int policy, int items);
    int osize;
    osize = (policy == WIDTH_ANY) ? $urandom_range(0, 3000) : $urandom_range(1000, 16383);
    run_phase(int'($urandom_range(0, 184320)) - 92160, $urandom_range(0, 2560),
              $urandom_range(0, 65535), $urandom_range(0, 255), osize, policy, items);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset setting
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // empty table, cruise
    send_word(KIND_SAMPLE, 1'b1, 12'd100, 16'd0, 1'b0, '0, '0);      // sector 56, very near
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // go to blocked, held
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // turning in place
    send_word(KIND_SAMPLE, 1'b1, 12'd0, 16'd65534, 1'b1, '0, '0);    // new scan, no echo
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // back to go, held
    send_word(KIND_CAMERA, 1'b0, '0, '0, 1'b0, 10'd639, 16'd1000);
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // steer to last column
    send_word(KIND_CAMERA, 1'b0, '0, '0, 1'b0, 10'd1023, 16'd999);   // just no target
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);
    send_word(KIND_CAMERA, 1'b0, '0, '0, 1'b0, 10'd1023, 16'd1000);  // centre past the image
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);                // right goes negative
    send_word(KIND_SAMPLE, 1'b1, 12'd4095, 16'd0, 1'b0, '0, '0);     // clear, then dropped
    send_word(KIND_SAMPLE, 1'b0, 12'd539, 16'd65534, 1'b0, '0, '0);  // last sector
    send_word(KIND_SAMPLE, 1'b0, 12'd540, 16'd0, 1'b0, '0, '0);      // exactly a full turn
    send_word(KIND_SAMPLE, 1'b0, 12'd180, 16'd0, 1'b0, '0, '0);      // angle zero
    send_word(KIND_SAMPLE, 1'b0, 12'd179, 16'd1, 1'b0, '0, '0);      // wraps to sector 71
    send_word(KIND_UNUSED, 1'b1, 12'hFFF, 16'hFFFF, 1'b1, 10'h3FF, 16'hFFFF);
    send_word(KIND_SAMPLE, 1'b0, 12'd65, 16'd499, 1'b0, '0, '0);     // first middle sector
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);
    send_word(KIND_SAMPLE, 1'b1, 12'd119, 16'd500, 1'b0, '0, '0);    // last middle, at limit
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);
    send_word(KIND_SAMPLE, 1'b0, 12'd120, 16'd0, 1'b0, '0, '0);      // just past the middle
    send_word(KIND_TICK, 1'b0, '0, '0, 1'b0, '0, '0);

    run_phase(-46080, 256, 500, 5, 1000, WIDTH_KEEP, 160);
    run_phase(-92160, 0, 0, 0, 16383, WIDTH_KEEP, 100);
    run_phase(92160, 2560, 65535, 255, 1000, WIDTH_KEEP, 100);
    run_phase(-30000, 300, 800, 17, 2000, WIDTH_KEEP, 160);
    run_phase(-92160, 2560, 65535, 255, 16383, WIDTH_KEEP, 120);
    rand_phase(WIDTH_KEEP, 120);
    rand_phase(WIDTH_IGNORE, 140);
    run_phase(-46080, 256, 2000, 200, 1000, WIDTH_IGNORE, 140);
    rand_phase(WIDTH_IGNORE, 120);
    rand_phase(WIDTH_ANY, 120);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && drives_owed == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
